/* design/owbm_pkg.sv */
package owbm_pkg;

  // Bus operation codes, also used as the request kind of an input beat.
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned CFG_WIDTH     = 16;
  localparam int unsigned CFG_COUNT     = 8;
  localparam int unsigned CFG_IDX_WIDTH = 4;

  // Timing register indexes.
  localparam logic [2:0] REG_RESET_LOW      = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
  localparam logic [2:0] REG_RESET_RECOVERY = 3'd2;
  localparam logic [2:0] REG_READ_LOW       = 3'd3;
  localparam logic [2:0] REG_READ_SAMPLE    = 3'd4;
  localparam logic [2:0] REG_READ_REST      = 3'd5;
  localparam logic [2:0] REG_WRITE_LOW      = 3'd6;
  localparam logic [2:0] REG_WRITE_SLOT     = 3'd7;

  typedef logic [CFG_WIDTH-1:0] cfg_word_t;

  // Timing register values after reset, in index order.
  localparam cfg_word_t CFG_RESET [CFG_COUNT] = '{
    16'd480, 16'd90, 16'd390, 16'd2, 16'd15, 16'd45, 16'd5, 16'd90
  };

  // One classified tick as it travels from the front to the sequencer.
  typedef struct packed {
    op_t        req;
    logic [7:0] tx_byte;
    logic       bus_level;
  } tick_item_t;

  // Head of the tick queue as seen by the sequencer.
  typedef struct packed {
    logic       valid;
    tick_item_t item;
  } queue_head_t;

  // One configuration write.
  typedef struct packed {
    logic                     we;
    logic [CFG_IDX_WIDTH-1:0] index;
    cfg_word_t                data;
  } cfg_write_t;

endpackage

/* design/onewire_bus_master_top.sv */
// 1-Wire bus master driven by a stream of time ticks.
// Input channel: one beat per tick. in_tuser carries the request kind
// (0 tick only, 1 reset with presence detect, 2 write byte, 3 read byte),
// in_tdata the byte to write and the sampled line level.
// Output channel: one beat per input beat with the line drive, busy, done,
// presence, the received byte (on the done tick of a read) and a reject flag
// for a command that arrived while another was running.
// Configuration channel: eight 16-bit slot timing registers; the user must
// write them only while the master is idle; the block does not enforce it.
// cfg_ready is always high. Throughput is one beat per cycle unless the
// receiver stalls; the sequencer advances once per beat. An accepted beat
// passes the two-entry tick queue, then the output register.
// When the receiver stalls, the output register holds its beat, the
// sequencer waits, and in_tready drops once both queue entries are filled.
// Reset returns the line to released, the sequencer to idle, clears the
// queue and loads the default timings.
module onewire_bus_master_top #(
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // req_type
  input  logic [15:0] in_tdata,   // tx_byte[7:0], bus_level[8], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  // pull_low[0], busy_res[1], done_res[2], presence[3], rx_byte[11:4],
  // rejected[12], zero fill
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  owbm_pkg::queue_head_t head;
  owbm_pkg::cfg_write_t  cfg_wr;
  logic                  pop;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  owbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .pop       (pop),
    .head      (head)
  );

  owbm_back #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .cfg_wr     (cfg_wr),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* design/owbm_front.sv */
module owbm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,   // req_type
  input  logic [15:0]          in_tdata,   // tx_byte[7:0], bus_level[8], zero fill
  input  logic                 pop,
  output owbm_pkg::queue_head_t head
);

  localparam int unsigned DEPTH = 2;

  owbm_pkg::tick_item_t queue_r [DEPTH];
  logic                 wr_ptr_r;
  logic                 wr_ptr_nxt;
  logic                 rd_ptr_r;
  logic                 rd_ptr_nxt;
  logic [1:0]           count_r;
  logic [1:0]           count_nxt;
  logic                 push;
  owbm_pkg::tick_item_t item_in;

  // Classify the incoming beat into a request kind and its payload.
  always_comb begin
    item_in.req       = owbm_pkg::op_t'(in_tuser[1:0]);
    item_in.tx_byte   = in_tdata[7:0];
    item_in.bus_level = in_tdata[8];
  end

  assign in_tready = (count_r != 2'(DEPTH));
  assign push      = in_tvalid && in_tready;

  assign head.valid = (count_r != 2'd0);
  assign head.item  = queue_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

/* design/owbm_back.sv */
module owbm_back #(
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  owbm_pkg::queue_head_t head,
  output logic                  pop,
  input  owbm_pkg::cfg_write_t  cfg_wr,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata
);

  localparam int unsigned TW = TICK_COUNT_WIDTH;
  localparam int unsigned LW = (TW > owbm_pkg::CFG_WIDTH) ? TW : owbm_pkg::CFG_WIDTH;

  owbm_pkg::cfg_word_t cfg_r [owbm_pkg::CFG_COUNT];

  owbm_pkg::op_t op_r, op_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          pres_r, pres_nxt;
  logic          low_r, low_nxt;

  logic          done;
  logic          rej;
  logic [7:0]    rxo;
  logic [TW-1:0] tick_inc;
  owbm_pkg::cfg_word_t len_raw;
  logic [LW-1:0] len_ext;
  logic [LW-1:0] cap_ext;
  logic          last_bit;
  owbm_pkg::tick_item_t it;

  logic          out_valid_r;
  logic [15:0]   out_data_r;
  logic [15:0]   out_data_nxt;

  assign it         = head.item;
  assign pop        = head.valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign last_bit   = (bit_r == 3'(owbm_pkg::BITS_PER_BYTE - 1));

  // Length of the running phase, zero taken as one, saturated to the counter.
  always_comb begin
    len_raw = owbm_pkg::cfg_word_t'(1);
    case (op_r)
      owbm_pkg::OP_RESET: begin
        if (phase_r != 2'd3) begin
          len_raw = cfg_r[3'(phase_r)];
        end
      end
      owbm_pkg::OP_READ: begin
        if (phase_r != 2'd3) begin
          len_raw = cfg_r[owbm_pkg::REG_READ_LOW + 3'(phase_r)];
        end
      end
      owbm_pkg::OP_WRITE: begin
        if (phase_r == 2'd0) begin
          len_raw = cfg_r[owbm_pkg::REG_WRITE_LOW];
        end else if (phase_r == 2'd1) begin
          len_raw = cfg_r[owbm_pkg::REG_WRITE_SLOT];
        end
      end
      default: begin
        len_raw = owbm_pkg::cfg_word_t'(1);
      end
    endcase
    if (len_raw == '0) begin
      len_raw = owbm_pkg::cfg_word_t'(1);
    end
    cap_ext = ~(LW'(0)) >> (LW - TW);
    len_ext = LW'(len_raw);
    if (len_ext > cap_ext) begin
      len_ext = cap_ext;
    end
  end

  // Sequencer step for one tick.
  always_comb begin
    op_nxt    = op_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    low_nxt   = low_r;
    done      = 1'b0;
    rej       = 1'b0;
    rxo       = 8'd0;
    tick_inc  = tick_r + TW'(1);

    if (op_r == owbm_pkg::OP_IDLE) begin
      // Idle: a command starts its first phase on this tick.
      if (it.req != owbm_pkg::OP_IDLE) begin
        op_nxt    = it.req;
        phase_nxt = 2'd0;
        tick_nxt  = '0;
        bit_nxt   = 3'd0;
        low_nxt   = 1'b1;
        case (it.req)
          owbm_pkg::OP_WRITE: shift_nxt = it.tx_byte;
          owbm_pkg::OP_READ:  shift_nxt = 8'd0;
          default:            pres_nxt  = 1'b0;
        endcase
      end
    end else begin
      rej      = (it.req != owbm_pkg::OP_IDLE);
      tick_nxt = tick_inc;
      if (LW'(tick_inc) >= len_ext) begin
        tick_nxt = '0;
        case (op_r)
          owbm_pkg::OP_RESET: begin
            if (phase_r == 2'd0) begin
              low_nxt   = 1'b0;
              phase_nxt = 2'd1;
            end else if (phase_r == 2'd1) begin
              pres_nxt  = ~it.bus_level;
              phase_nxt = 2'd2;
            end else begin
              done = 1'b1;
            end
          end
          owbm_pkg::OP_READ: begin
            if (phase_r == 2'd0) begin
              low_nxt   = 1'b0;
              phase_nxt = 2'd1;
            end else if (phase_r == 2'd1) begin
              shift_nxt = {it.bus_level, shift_r[7:1]};
              phase_nxt = 2'd2;
            end else if (phase_r == 2'd2 && !last_bit) begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = 2'd0;
              low_nxt   = 1'b1;
            end else begin
              if (phase_r == 2'd2) begin
                rxo = shift_r;
              end
              done = 1'b1;
            end
          end
          default: begin
            // Write slot.
            if (phase_r == 2'd0) begin
              low_nxt   = ~shift_r[0];
              phase_nxt = 2'd1;
            end else if (phase_r == 2'd1) begin
              low_nxt   = 1'b0;
              phase_nxt = 2'd2;
            end else if (phase_r == 2'd2) begin
              shift_nxt = {1'b0, shift_r[7:1]};
              if (last_bit) begin
                done = 1'b1;
              end else begin
                bit_nxt   = bit_r + 3'd1;
                phase_nxt = 2'd0;
                low_nxt   = 1'b1;
              end
            end else begin
              done = 1'b1;
            end
          end
        endcase
        if (done) begin
          op_nxt    = owbm_pkg::OP_IDLE;
          phase_nxt = 2'd0;
          bit_nxt   = 3'd0;
          low_nxt   = 1'b0;
        end
      end
    end

    out_data_nxt = {3'd0, rej, rxo, pres_nxt, done,
                    (op_nxt != owbm_pkg::OP_IDLE), low_nxt};
  end

  // Sequencer state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= owbm_pkg::OP_IDLE;
      phase_r     <= 2'd0;
      tick_r      <= '0;
      bit_r       <= 3'd0;
      shift_r     <= 8'd0;
      pres_r      <= 1'b0;
      low_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        op_r    <= op_nxt;
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        pres_r  <= pres_nxt;
        low_r   <= low_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Timing registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= owbm_pkg::CFG_RESET;
    end else if (cfg_wr.we && cfg_wr.index < owbm_pkg::CFG_IDX_WIDTH'(owbm_pkg::CFG_COUNT)) begin
      cfg_r[cfg_wr.index[2:0]] <= cfg_wr.data;
    end
  end

endmodule
